/* sv/tpaf_pkg.sv */
// shared types and constants for the triac phase-angle firing block
`timescale 1ns / 1ps
`default_nettype none

package tpaf_pkg;

  // field widths
  localparam int unsigned TIME_W   = 15;
  localparam int unsigned PULSE_W  = 10;
  localparam int unsigned POWER_W  = 7;
  localparam int unsigned PROD_W   = 22;

  // interval window for a valid mains period, exclusive at both ends
  localparam int unsigned PERIOD_LOW     = 17000;
  localparam int unsigned PERIOD_HIGH    = 23000;
  localparam int unsigned FILTER_WEIGHT  = 7;
  localparam int unsigned PRESENT_WINDOW = 200000;
  localparam int unsigned FULL_POWER     = 100;

  // x / 100 as (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2^22
  localparam int unsigned RECIP_100   = 5368710;
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned RECIP_SHIFT = 29;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_HALF_CYCLE = 2'd0,
    REG_MIN_DELAY  = 2'd1,
    REG_PULSE      = 2'd2
  } cfg_reg_t;

  // input item as taken from the stream
  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic               enable;
    logic               zcd_edge;
  } tick_raw_t;

  // timing settings the delay path needs
  typedef struct packed {
    logic [TIME_W-1:0] half_cycle;
    logic [TIME_W-1:0] min_delay;
  } delay_cfg_t;

  // item leaving the delay path for the firing core
  typedef struct packed {
    logic              zcd_edge;
    logic              arm;
    logic [TIME_W-1:0] delay;
  } tick_item_t;

endpackage

`default_nettype wire

/* sv/tpaf_front.sv */
// input register and two-stage firing delay computation
`timescale 1ns / 1ps
`default_nettype none

module tpaf_front import tpaf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire tick_raw_t  in_item,
  input  wire delay_cfg_t cfg,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tick_item_t      out_item
);

  localparam int unsigned QPROD_W = PROD_W + RECIP_W;

  // stage valid bits
  logic v1, v2, v3;
  logic r1, r2, r3;

  // stage one: registered input
  logic               edge1;
  logic               enable1;
  logic [POWER_W-1:0] power1;

  // stage two: scaled product and clamped minimum
  logic               edge2;
  logic               arm2;
  logic [PROD_W-1:0]  prod2;
  logic [TIME_W-1:0]  min2;

  // stage three: finished delay
  logic               edge3;
  logic               arm3;
  logic [TIME_W-1:0]  delay3;

  // combinational terms
  logic [POWER_W-1:0] p_sat;
  logic [POWER_W-1:0] weight;
  logic [TIME_W-1:0]  m_clamp;
  logic [TIME_W-1:0]  span;
  logic [PROD_W-1:0]  prod;
  logic [QPROD_W-1:0] qprod;
  logic [TIME_W-1:0]  quot;

  // stall chain, each stage moves when the next one can take it
  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  // power saturation, minimum clamp and weighted span
  always_comb begin
    p_sat   = (power1 > POWER_W'(FULL_POWER)) ? POWER_W'(FULL_POWER) : power1;
    weight  = POWER_W'(FULL_POWER) - p_sat;
    m_clamp = (cfg.min_delay > cfg.half_cycle) ? cfg.half_cycle : cfg.min_delay;
    span    = cfg.half_cycle - m_clamp;
    prod    = PROD_W'(weight) * PROD_W'(span);
  end

  // divide by one hundred through the reciprocal
  always_comb begin
    qprod = QPROD_W'(prod2) * QPROD_W'(RECIP_100);
    quot  = qprod[RECIP_SHIFT +: TIME_W];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (r1) begin
      edge1   <= in_item.zcd_edge;
      enable1 <= in_item.enable;
      power1  <= in_item.power;
    end
    if (r2) begin
      edge2 <= edge1;
      arm2  <= enable1 && (power1 != '0);
      prod2 <= prod;
      min2  <= m_clamp;
    end
    if (r3) begin
      edge3  <= edge2;
      arm3   <= arm2;
      delay3 <= quot + min2;
    end
  end

  assign out_valid      = v3;
  assign out_item.zcd_edge = edge3;
  assign out_item.arm   = arm3;
  assign out_item.delay = delay3;

endmodule

`default_nettype wire

/* sv/triac_phase_angle_firing.sv */
// top level of the triac phase-angle firing controller
`timescale 1ns / 1ps
`default_nettype none

// Phase-angle triac firing controller. Each input item is one microsecond
// tick carrying the zero-cross edge flag, enable and power level; each item
// gives exactly one result item with the gate level, the filtered mains
// period and the mains-present flag. One item is taken per clock cycle
// while the result side keeps taking results; each item passes the input
// register, two registered multiply stages for the firing delay, then the
// firing core feeding the output register. A result waiting on the result
// side stalls the whole pipeline back to the input in the same cycle, so no
// item is lost. Configuration is taken on any cycle
// (cfg_ready is always high) and must only change while no item is in flight.
module triac_phase_angle_firing import tpaf_pkg::*; #(
  parameter int unsigned TIMESTAMP_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // zcd_edge [0], enable [1], power [8:2], zero fill above
  input  wire logic [15:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // gate [0], period_us [15:1], mains_present [16], zero fill above
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);

  // configuration registers
  logic [TIME_W-1:0]  half_cycle_us;
  logic [TIME_W-1:0]  min_delay_us;
  logic [PULSE_W-1:0] pulse_us;

  // firing state
  logic [TIMESTAMP_BITS-1:0] tick_time;
  logic [TIMESTAMP_BITS-1:0] last_edge_time;
  logic [TIME_W-1:0]         filtered_period;
  logic [TIME_W-1:0]         firing_delay;
  logic [1:0]                pulses_pending;
  logic [PULSE_W-1:0]        gate_remaining;

  logic [TIMESTAMP_BITS-1:0] last_edge_time_next;
  logic [TIME_W-1:0]         filtered_period_next;
  logic [TIME_W-1:0]         firing_delay_next;
  logic [1:0]                pulses_pending_next;
  logic [PULSE_W-1:0]        gate_remaining_next;

  // output register
  logic              out_gate;
  logic [TIME_W-1:0] out_period;
  logic              out_present;

  // front pipeline link
  tick_raw_t  raw_item;
  delay_cfg_t dcfg;
  tick_item_t fr_item;
  logic       fr_valid;
  logic       core_ready;
  logic       take;

  // core terms
  logic [TIMESTAMP_BITS-1:0] interval;
  logic [TIMESTAMP_BITS-1:0] elapsed;
  logic                      in_range;
  logic [18:0]               blend_sum;
  logic [TIME_W:0]           target;
  logic [PULSE_W-1:0]        gate_count;
  logic                      gate_on;
  logic                      present;

  // configuration write port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_cycle_us <= TIME_W'(10000);
      min_delay_us  <= TIME_W'(500);
      pulse_us      <= PULSE_W'(100);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HALF_CYCLE: half_cycle_us <= cfg_data;
        REG_MIN_DELAY:  min_delay_us  <= cfg_data;
        REG_PULSE:      pulse_us      <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // input unpacking
  assign raw_item.zcd_edge       = s_axis_tdata[0];
  assign raw_item.enable         = s_axis_tdata[1];
  assign raw_item.power          = s_axis_tdata[8:2];
  assign dcfg.half_cycle         = half_cycle_us;
  assign dcfg.min_delay          = min_delay_us;

  tpaf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (raw_item),
    .cfg       (dcfg),
    .out_valid (fr_valid),
    .out_ready (core_ready),
    .out_item  (fr_item)
  );

  assign core_ready = !m_axis_tvalid || m_axis_tready;
  assign take       = fr_valid && core_ready;

  // edge handling, pulse start and gate count for one tick
  always_comb begin
    interval  = tick_time - last_edge_time;
    in_range  = (interval > TIMESTAMP_BITS'(PERIOD_LOW)) &&
                (interval < TIMESTAMP_BITS'(PERIOD_HIGH));
    blend_sum = 19'(filtered_period) * 19'(FILTER_WEIGHT) + 19'(interval[TIME_W-1:0]);

    last_edge_time_next  = last_edge_time;
    filtered_period_next = filtered_period;
    firing_delay_next    = firing_delay;
    pulses_pending_next  = pulses_pending;

    if (fr_item.zcd_edge) begin
      last_edge_time_next = tick_time;
      if (in_range) begin
        if (filtered_period == '0) filtered_period_next = interval[TIME_W-1:0];
        else                      filtered_period_next = blend_sum[TIME_W+2:3];
      end
      pulses_pending_next = 2'd0;
      if (fr_item.arm) begin
        firing_delay_next   = fr_item.delay;
        pulses_pending_next = 2'd2;
      end
    end

    elapsed = fr_item.zcd_edge ? '0 : interval;

    // second pulse sits one half cycle after the first
    target = (TIME_W+1)'(firing_delay_next) +
             ((pulses_pending_next == 2'd1) ? (TIME_W+1)'(half_cycle_us) : '0);

    gate_count = gate_remaining;
    if (gate_remaining == '0 && pulses_pending_next != 2'd0 &&
        elapsed >= TIMESTAMP_BITS'(target)) begin
      gate_count          = pulse_us;
      pulses_pending_next = pulses_pending_next - 2'd1;
    end

    gate_on             = gate_count != '0;
    present             = (filtered_period_next != '0) &&
                          (elapsed < TIMESTAMP_BITS'(PRESENT_WINDOW));
    gate_remaining_next = gate_on ? gate_count - PULSE_W'(1) : '0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_time       <= '0;
      last_edge_time  <= '0;
      filtered_period <= '0;
      firing_delay    <= '0;
      pulses_pending  <= 2'd0;
      gate_remaining  <= '0;
    end else if (take) begin
      tick_time       <= tick_time + TIMESTAMP_BITS'(1);
      last_edge_time  <= last_edge_time_next;
      filtered_period <= filtered_period_next;
      firing_delay    <= firing_delay_next;
      pulses_pending  <= pulses_pending_next;
      gate_remaining  <= gate_remaining_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_gate    <= gate_on;
      out_period  <= filtered_period_next;
      out_present <= present;
    end
  end

  assign m_axis_tdata = {7'd0, out_present, out_period, out_gate};

  // at most two pulses are ever armed
  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    pulses_pending != 2'd3)
    else $error("pulse count out of range");

  // a known period always lies inside the accepted window
  a_period_window: assert property (@(posedge clk) disable iff (rst)
    filtered_period == '0 ||
    (filtered_period > TIME_W'(PERIOD_LOW) && filtered_period < TIME_W'(PERIOD_HIGH)))
    else $error("filtered period outside window");

  // each consumed item advances time by one tick
  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    take |=> tick_time == $past(tick_time) + TIMESTAMP_BITS'(1))
    else $error("tick time did not advance");

  // a consumed item always leaves a result waiting
  a_result_valid: assert property (@(posedge clk) disable iff (rst)
    take |=> m_axis_tvalid)
    else $error("result lost");

endmodule

`default_nettype wire
